### hdl/alpha_threshold_bounding_box_top_defines.svh
// Assertion macros shared by the RTL files.
// ASSERT_IMPLIES: cons holds in the same cycle as ante.
// ASSERT_NEXT: cons holds in the cycle after ante.
`ifndef ALPHA_THRESHOLD_BOUNDING_BOX_TOP_DEFINES_SVH
`define ALPHA_THRESHOLD_BOUNDING_BOX_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### hdl/atbb_pkg.sv
`default_nettype none

package atbb_pkg;

  localparam int MAX_DIMENSION = 4096;

  // coordinate counters hold 0 .. MAX_DIMENSION-1
  localparam int COORD_W = (MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1;
  // clamped dimension holds 1 .. MAX_DIMENSION
  localparam int DIM_W   = COORD_W + 1;

  localparam int CFG_DIM_W   = 13;
  localparam int ALPHA_W     = 8;
  localparam int BOX_W       = 12;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_DIM_W-1:0] DIM_RESET       = 13'd4096;
  localparam logic [ALPHA_W-1:0]   THRESHOLD_RESET = 8'd126;
  localparam logic [ALPHA_W-1:0]   MASK_ON         = 8'd255;
  localparam logic [ALPHA_W-1:0]   MASK_OFF        = 8'd0;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH     = 2'd0,
    REG_IMAGE_HEIGHT    = 2'd1,
    REG_ALPHA_THRESHOLD = 2'd2
  } cfg_reg_t;

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t column;
    coord_t row;
    logic   last_column;
    logic   last_row;
  } pos_t;

  typedef struct packed {
    logic [BOX_W-1:0] left;
    logic [BOX_W-1:0] top;
    logic [BOX_W-1:0] right;
    logic [BOX_W-1:0] bottom;
  } box_t;

  // zero acts as one, anything above the maximum acts as the maximum
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > 32'(MAX_DIMENSION)) begin
      r = DIM_W'(MAX_DIMENSION);
    end else begin
      r = DIM_W'(32'(v));
    end
    return r;
  endfunction

  // reported coordinates keep the low bits
  function automatic logic [BOX_W-1:0] to_box(input coord_t c);
    return BOX_W'(32'(c));
  endfunction

endpackage

`default_nettype wire

### hdl/atbb_position.sv
`default_nettype none

module atbb_position
  import atbb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 step,
  input  wire logic [CFG_DIM_W-1:0] image_width,
  input  wire logic [CFG_DIM_W-1:0] image_height,
  output pos_t                      pos
);

  coord_t column;
  coord_t row;
  logic [DIM_W-1:0] w;
  logic [DIM_W-1:0] h;

  always_comb begin
    w = clamp_dim(image_width);
    h = clamp_dim(image_height);
    pos.column      = column;
    pos.row         = row;
    // at or past the last column also ends the row (size change mid frame)
    pos.last_column = (DIM_W'(column) + DIM_W'(1)) >= w;
    pos.last_row    = (DIM_W'(row) + DIM_W'(1)) >= h;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
      row    <= '0;
    end else if (step) begin
      if (pos.last_column && pos.last_row) begin
        column <= '0;
        row    <= '0;
      end else if (pos.last_column) begin
        column <= '0;
        row    <= row + coord_t'(1);
      end else begin
        column <= column + coord_t'(1);
      end
    end
  end

endmodule

`default_nettype wire

### hdl/atbb_box.sv
`default_nettype none

`include "alpha_threshold_bounding_box_top_defines.svh"

module atbb_box
  import atbb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic step,
  input  wire logic selected,
  input  wire pos_t pos,
  output box_t      report
);

  logic   any_selected;
  coord_t min_column;
  coord_t max_column;
  coord_t min_row;
  coord_t max_row;

  logic   any_selected_next;
  coord_t min_column_next;
  coord_t max_column_next;
  coord_t min_row_next;
  coord_t max_row_next;
  logic   done;

  always_comb begin
    any_selected_next = any_selected;
    min_column_next   = min_column;
    max_column_next   = max_column;
    min_row_next      = min_row;
    max_row_next      = max_row;
    if (selected) begin
      if (!any_selected) begin
        any_selected_next = 1'b1;
        min_column_next   = pos.column;
        max_column_next   = pos.column;
        min_row_next      = pos.row;
        max_row_next      = pos.row;
      end else begin
        if (pos.column < min_column) min_column_next = pos.column;
        if (pos.column > max_column) max_column_next = pos.column;
        if (pos.row < min_row) min_row_next = pos.row;
        if (pos.row > max_row) max_row_next = pos.row;
      end
    end
  end

  assign done = pos.last_column && pos.last_row;

  // box includes the current pixel; zeros except at a frame end with a hit
  always_comb begin
    report = '0;
    if (done && any_selected_next) begin
      report.left   = to_box(min_column_next);
      report.top    = to_box(min_row_next);
      report.right  = to_box(max_column_next);
      report.bottom = to_box(max_row_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      any_selected <= 1'b0;
      min_column   <= '0;
      max_column   <= '0;
      min_row      <= '0;
      max_row      <= '0;
    end else if (step) begin
      if (done) begin
        any_selected <= 1'b0;
        min_column   <= '0;
        max_column   <= '0;
        min_row      <= '0;
        max_row      <= '0;
      end else begin
        any_selected <= any_selected_next;
        min_column   <= min_column_next;
        max_column   <= max_column_next;
        min_row      <= min_row_next;
        max_row      <= max_row_next;
      end
    end
  end

  `ASSERT_IMPLIES(a_box_ordered, clk, rst, any_selected,
    (min_column <= max_column) && (min_row <= max_row))
  `ASSERT_IMPLIES(a_empty_box_zero, clk, rst, !any_selected,
    (min_column == '0) && (max_column == '0) && (min_row == '0) && (max_row == '0))
  `ASSERT_NEXT(a_frame_end_clears, clk, rst, step && done, !any_selected)

endmodule

`default_nettype wire

### hdl/alpha_threshold_bounding_box_top.sv
// Alpha threshold bounding box. Each transfer on the input channel carries
// the alpha byte of one mask pixel in raster order; each produces one result
// transfer with the binary mask alpha (255 above the threshold, else 0) and,
// on the frame's last pixel, frame_done with the bounding box of the selected
// pixels (all zeros when none, and zeros on every other pixel). Throughput is
// one pixel per clock while results are taken; each pixel passes an input
// register, then the compare and min/max update stage that loads the result
// register. The output register lets a new pixel be taken while a result
// waits. The user writes frame size and threshold through the cfg port only
// while idle (not enforced); width/height 0 acts as 1, above 4096 as 4096.

`default_nettype none

`include "alpha_threshold_bounding_box_top_defines.svh"

module alpha_threshold_bounding_box_top
  import atbb_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  // config write port
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  // pixel input channel
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [ALPHA_W-1:0]     pixel_alpha,
  // result channel
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [ALPHA_W-1:0]          mask_alpha,
  output logic                        frame_done,
  output logic [BOX_W-1:0]            box_left,
  output logic [BOX_W-1:0]            box_top,
  output logic [BOX_W-1:0]            box_right,
  output logic [BOX_W-1:0]            box_bottom
);

  // configuration registers
  logic [CFG_DIM_W-1:0] image_width;
  logic [CFG_DIM_W-1:0] image_height;
  logic [ALPHA_W-1:0]   alpha_threshold;

  // input register
  logic               s1_valid;
  logic [ALPHA_W-1:0] s1_alpha;

  logic step;       // the pixel in s1 is processed this cycle
  logic selected;
  pos_t pos;
  box_t report;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= DIM_RESET;
      image_height    <= DIM_RESET;
      alpha_threshold <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:     image_width     <= cfg_data[CFG_DIM_W-1:0];
        REG_IMAGE_HEIGHT:    image_height    <= cfg_data[CFG_DIM_W-1:0];
        REG_ALPHA_THRESHOLD: alpha_threshold <= cfg_data[ALPHA_W-1:0];
        default: ;  // unknown index: write dropped
      endcase
    end
  end

  // s1 moves on whenever the result register is free or being emptied
  assign step     = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || !out_valid || out_ready;
  assign selected = s1_alpha > alpha_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (step) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_alpha <= pixel_alpha;
    end
  end

  atbb_position u_position (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .image_width  (image_width),
    .image_height (image_height),
    .pos          (pos)
  );

  atbb_box u_box (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .selected (selected),
    .pos      (pos),
    .report   (report)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      mask_alpha <= selected ? MASK_ON : MASK_OFF;
      frame_done <= pos.last_column && pos.last_row;
      box_left   <= report.left;
      box_top    <= report.top;
      box_right  <= report.right;
      box_bottom <= report.bottom;
    end
  end

  `ASSERT_IMPLIES(a_box_zero_mid_frame, clk, rst, out_valid && !frame_done,
    (box_left == '0) && (box_top == '0) && (box_right == '0) && (box_bottom == '0))
  `ASSERT_NEXT(a_accept_fills_s1, clk, rst, in_valid && in_ready, s1_valid)
  `ASSERT_NEXT(a_result_held, clk, rst, out_valid && !out_ready, out_valid)

endmodule

`default_nettype wire

### tb/atbb_monitor.sv
`timescale 1ns / 100ps

module atbb_monitor
  import atbb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [ALPHA_W-1:0]     pixel_alpha,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [ALPHA_W-1:0]     mask_alpha,
  input  logic                   frame_done,
  input  logic [BOX_W-1:0]       box_left,
  input  logic [BOX_W-1:0]       box_top,
  input  logic [BOX_W-1:0]       box_right,
  input  logic [BOX_W-1:0]       box_bottom,
  output int                     mismatches,
  output int                     outstanding,
  output int                     frames_seen
);

  typedef struct packed {
    logic [ALPHA_W-1:0] mask;
    logic               done;
    box_t               box;
  } pixel_result_t;

  // register mirror
  logic [CFG_DIM_W-1:0] width_reg;
  logic [CFG_DIM_W-1:0] height_reg;
  logic [ALPHA_W-1:0]   thr_reg;

  // frame tracker
  coord_t col_pos;
  coord_t row_pos;
  logic   seen_any;
  coord_t min_col;
  coord_t max_col;
  coord_t min_row;
  coord_t max_row;

  pixel_result_t pending_pixel_results[$];
  int            error_count = 0;
  int            frame_count = 0;

  function automatic int unsigned effective_dim(input logic [CFG_DIM_W-1:0] v);
    if (v == '0) return 1;
    if (32'(v) > 32'(MAX_DIMENSION)) return MAX_DIMENSION;
    return 32'(v);
  endfunction

  function automatic void clear_tracker();
    col_pos  = '0;
    row_pos  = '0;
    seen_any = 1'b0;
    min_col  = '0;
    max_col  = '0;
    min_row  = '0;
    max_row  = '0;
  endfunction

  // Mask and box for one pixel; advances the raster position.
  function automatic pixel_result_t track_pixel(input logic [ALPHA_W-1:0] alpha);
    pixel_result_t r;
    logic          sel;
    logic          end_col;
    logic          end_row;
    sel     = alpha > thr_reg;
    end_col = (32'(col_pos) + 1) >= effective_dim(width_reg);
    end_row = (32'(row_pos) + 1) >= effective_dim(height_reg);
    if (sel) begin
      if (!seen_any) begin
        min_col  = col_pos;
        max_col  = col_pos;
        min_row  = row_pos;
        max_row  = row_pos;
        seen_any = 1'b1;
      end else begin
        if (col_pos < min_col) min_col = col_pos;
        if (col_pos > max_col) max_col = col_pos;
        if (row_pos < min_row) min_row = row_pos;
        if (row_pos > max_row) max_row = row_pos;
      end
    end
    r.mask = sel ? MASK_ON : MASK_OFF;
    r.done = end_col && end_row;
    if (r.done && seen_any) begin
      r.box = '{left: BOX_W'(min_col), top: BOX_W'(min_row),
                right: BOX_W'(max_col), bottom: BOX_W'(max_row)};
    end else begin
      r.box = '0;
    end
    if (r.done) begin
      clear_tracker();
    end else if (end_col) begin
      col_pos = '0;
      row_pos = row_pos + coord_t'(1);
    end else begin
      col_pos = col_pos + coord_t'(1);
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] got_v);
    if (got_v !== exp_v) begin
      error_count++;
      $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    pixel_result_t exp_r;
    if (rst) begin
      width_reg  = DIM_RESET;
      height_reg = DIM_RESET;
      thr_reg    = THRESHOLD_RESET;
      clear_tracker();
      pending_pixel_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:     width_reg  = cfg_data[CFG_DIM_W-1:0];
          REG_IMAGE_HEIGHT:    height_reg = cfg_data[CFG_DIM_W-1:0];
          REG_ALPHA_THRESHOLD: thr_reg    = cfg_data[ALPHA_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        pending_pixel_results.push_back(track_pixel(pixel_alpha));
      if (out_valid && out_ready) begin
        if (pending_pixel_results.size() == 0) begin
          error_count++;
          $display("%0t: result transfer expected none, got mask %0d done %0d",
                   $time, mask_alpha, frame_done);
        end else begin
          exp_r = pending_pixel_results.pop_front();
          if (exp_r.done) frame_count++;
          check_field("mask_alpha", 16'(exp_r.mask), 16'(mask_alpha));
          check_field("frame_done", 16'(exp_r.done), 16'(frame_done));
          check_field("box_left", 16'(exp_r.box.left), 16'(box_left));
          check_field("box_top", 16'(exp_r.box.top), 16'(box_top));
          check_field("box_right", 16'(exp_r.box.right), 16'(box_right));
          check_field("box_bottom", 16'(exp_r.box.bottom), 16'(box_bottom));
        end
      end
    end
    mismatches  <= error_count;
    outstanding <= pending_pixel_results.size();
    frames_seen <= frame_count;
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import atbb_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PIXELS = 1350;
  localparam int MIN_FRAMES    = 48;   // keep going until this many frame ends came back
  localparam int HOLD_CYCLES   = 200;  // long result-side hold-off
  localparam int DRAIN_CYCLES  = 8;    // two-stage pipe, plenty of margin
  localparam int IDLE_PCT      = 32;
  // index 3 decodes to no register
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  logic                   clk         = 1'b0;
  logic                   rst         = 1'b1;
  logic                   cfg_we      = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data    = '0;
  logic                   in_valid    = 1'b0;
  logic                   in_ready;
  logic [ALPHA_W-1:0]     pixel_alpha = '0;
  logic                   out_valid;
  logic                   out_ready   = 1'b0;
  logic [ALPHA_W-1:0]     mask_alpha;
  logic                   frame_done;
  logic [BOX_W-1:0]       box_left;
  logic [BOX_W-1:0]       box_top;
  logic [BOX_W-1:0]       box_right;
  logic [BOX_W-1:0]       box_bottom;

  int mismatches;
  int outstanding;
  int frames_seen;
  int cycle_count     = 0;
  int sender_idle_pct = IDLE_PCT;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  alpha_threshold_bounding_box_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pixel_alpha(pixel_alpha),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .mask_alpha (mask_alpha),
    .frame_done (frame_done),
    .box_left   (box_left),
    .box_top    (box_top),
    .box_right  (box_right),
    .box_bottom (box_bottom)
  );

  // Watches cfg writes and both channels, predicts and compares.
  atbb_monitor u_monitor (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pixel_alpha(pixel_alpha),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .mask_alpha (mask_alpha),
    .frame_done (frame_done),
    .box_left   (box_left),
    .box_top    (box_top),
    .box_right  (box_right),
    .box_bottom (box_bottom),
    .mismatches (mismatches),
    .outstanding(outstanding),
    .frames_seen(frames_seen)
  );

  // Watchdog: a hung handshake or a lost result ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side. Random back-pressure, then one long hold-off once a few
  // hundred transfers are through and the pixel side is offering (it keeps
  // offering, so the pipe fills and in_ready drops), then a stretch with
  // ready held high.
  initial begin : result_sink
    int taken;
    int hold_left;
    bit hold_done;
    taken     = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) taken++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && taken >= 300 && in_valid) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (taken >= 600 && taken < 900) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // One pixel transfer. Optional idle cycles first, then valid is held with
  // a stable payload until in_ready is seen at an edge. Returns at the edge
  // of the transfer, so the next call touches in_valid only once per step.
  task automatic send_pixel(input logic [ALPHA_W-1:0] alpha);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    pixel_alpha <= alpha;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stop offering and wait until every pixel has its result back.
  // Every pixel yields a result, so an empty queue means an idle pipe.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Frame size and threshold, written only with the pipe empty. The frame
  // counters are not touched, so this also lands in the middle of a frame.
  // Upper data bits on the threshold write are junk the block must drop.
  task automatic set_frame(input logic [CFG_DIM_W-1:0] w, input logic [CFG_DIM_W-1:0] h,
                           input logic [ALPHA_W-1:0] thr, input bit poke_unused);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_index <= REG_ALPHA_THRESHOLD;
    cfg_data  <= CFG_DATA_W'({$urandom, thr});
    @(posedge clk);
    if (poke_unused) begin
      cfg_index <= REG_UNUSED;
      cfg_data  <= CFG_DATA_W'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Mostly small frames so boxes come back often; now and then zero
  // (acts as one) or oversize (clamps to the maximum).
  function automatic logic [CFG_DIM_W-1:0] pick_dim();
    case ($urandom_range(19))
      0:       return '0;
      1:       return CFG_DIM_W'($urandom_range((1 << CFG_DIM_W) - 1, MAX_DIMENSION + 1));
      2, 3:    return CFG_DIM_W'($urandom_range(40, 9));
      default: return CFG_DIM_W'($urandom_range(8, 1));
    endcase
  endfunction

  function automatic logic [ALPHA_W-1:0] pick_threshold();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return ALPHA_W'($urandom);
    endcase
  endfunction

  // mode 0: uniform; 1: sparse selection, so boxes stay tight;
  // 2: right at the threshold, both sides of the strict compare
  function automatic logic [ALPHA_W-1:0] pick_alpha(input logic [ALPHA_W-1:0] thr,
                                                    input int mode);
    case (mode)
      1:       return ($urandom_range(15) == 0) ? ALPHA_W'($urandom) : '0;
      2:       return thr + ALPHA_W'($urandom_range(1));
      default: return ALPHA_W'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    int                   sent;
    int                   span;
    int                   mode;
    int                   eff_w;
    int                   eff_h;
    logic [CFG_DIM_W-1:0] w;
    logic [CFG_DIM_W-1:0] h;
    logic [ALPHA_W-1:0]   thr;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // --- directed ---
    // reset config (4096 x 4096, threshold 126): both sides of the threshold
    send_pixel(8'd0);
    send_pixel(8'd126);
    send_pixel(8'd127);
    send_pixel(8'd255);
    // shrink mid frame: column counter already past the new last column
    set_frame(13'd3, 13'd2, 8'd126, 1'b1);
    send_pixel(8'd200);
    send_pixel(8'd0);
    send_pixel(8'd0);
    send_pixel(8'd255);
    send_pixel(8'd0);
    send_pixel(8'd127);
    // zero size acts as one: every pixel is a frame; alpha 0 gives an empty box
    set_frame(13'd0, 13'd0, 8'd0, 1'b0);
    send_pixel(8'd0);
    send_pixel(8'd1);
    send_pixel(8'd255);
    // oversize clamps to the maximum; threshold 255 selects nothing
    set_frame(13'h1FFF, 13'h1FFF, 8'd255, 1'b1);
    send_pixel(8'd255);
    send_pixel(8'd254);
    // back down to 2 x 2 mid frame
    set_frame(13'd2, 13'd2, 8'd254, 1'b0);
    send_pixel(8'd255);
    send_pixel(8'd0);
    send_pixel(8'd255);
    send_pixel(8'd255);
    send_pixel(8'd0);
    send_pixel(8'd255);

    // --- random ---
    // Mostly whole frames after each config change; sometimes a few extra
    // pixels, and oversize segments are cut short, so the next change hits
    // mid frame.
    sent = 0;
    while (sent < RANDOM_PIXELS || frames_seen < MIN_FRAMES) begin
      w    = pick_dim();
      h    = pick_dim();
      thr  = pick_threshold();
      mode = $urandom_range(2);
      set_frame(w, h, thr, $urandom_range(3) == 0);
      eff_w = (w == 0) ? 1 : int'(w);
      eff_h = (h == 0) ? 1 : int'(h);
      if (eff_w * eff_h <= 400)
        span = eff_w * eff_h * $urandom_range(3, 1) +
               (($urandom_range(3) == 0) ? $urandom_range(5) : 0);
      else
        span = $urandom_range(40, 5);
      repeat (span) begin
        // a stretch with back-to-back pixel transfers
        sender_idle_pct = (sent >= 300 && sent < 600) ? 0 : IDLE_PCT;
        send_pixel(pick_alpha(thr, mode));
        sent++;
      end
    end
    sender_idle_pct = IDLE_PCT;

    // wait out every result, then a few more cycles for strays
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/atbb_pkg.sv
hdl/atbb_position.sv
hdl/atbb_box.sv
hdl/alpha_threshold_bounding_box_top.sv
tb/atbb_monitor.sv
tb/testbench.sv
